// ===== hw/rtl/apc_pkg.sv =====
// Shared types and constants of the airbag plausibility crash detector.
package apc_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned STAMP_WIDTH  = 32;
  localparam int unsigned THR_WIDTH    = 8;
  localparam int unsigned TOL_WIDTH    = 7;
  localparam int unsigned FACTOR_WIDTH = TOL_WIDTH + 2;
  localparam int unsigned PROD_WIDTH   = SAMPLE_WIDTH + FACTOR_WIDTH;
  localparam int unsigned ADDR_WIDTH   = 5;
  localparam int unsigned DATA_WIDTH   = 32;

  localparam logic signed [FACTOR_WIDTH-1:0] PERCENT_FULL = FACTOR_WIDTH'(100);

  localparam logic [THR_WIDTH-1:0]             RST_DEFECT_LIMIT      = 8'd3;
  localparam logic [THR_WIDTH-1:0]             RST_CLEAR_LIMIT       = 8'd3;
  localparam logic [THR_WIDTH-1:0]             RST_FIRE_LIMIT        = 8'd3;
  localparam logic signed [SAMPLE_WIDTH-1:0]   RST_CRASH_LEVEL       = 16'sd3;
  localparam logic [TOL_WIDTH-1:0]             RST_TOLERANCE_PERCENT = 7'd5;

  typedef enum logic [2:0] {
    REG_DEFECT_LIMIT      = 3'd0,
    REG_CLEAR_LIMIT       = 3'd1,
    REG_FIRE_LIMIT        = 3'd2,
    REG_CRASH_LEVEL       = 3'd3,
    REG_TOLERANCE_PERCENT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [THR_WIDTH-1:0]           defect_limit;
    logic [THR_WIDTH-1:0]           clear_limit;
    logic [THR_WIDTH-1:0]           fire_limit;
    logic signed [SAMPLE_WIDTH-1:0] crash_level;
    logic [TOL_WIDTH-1:0]           tolerance_percent;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_WIDTH-1:0]         time_stamp;
    logic signed [SAMPLE_WIDTH-1:0] sample_a;
    logic signed [SAMPLE_WIDTH-1:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic plausible;
    logic defect;
    logic fire;
  } out_item_t;

  typedef struct packed {
    logic ok;
    logic crash;
  } chk_t;

endpackage

// ===== hw/rtl/airbag_plausibility_crash_detector_top.sv =====
// Top level of the airbag plausibility crash detector: handshake stages and register port.
//
// Airbag plausibility crash detector. Each item (time stamp plus two redundant
// acceleration samples) yields exactly one result item: accepted, plausible,
// defect and fire. The block takes one item per clock cycle while the output is not
// stalled; an item is captured in the input register, then checked and applied to
// the detector state, and its result is loaded into the output register at the same
// edge as the state update. The rate is set by the update of the counter state, which
// every item reads and every item with a fresh time stamp writes. An output register
// separates the channels: a new item is taken while an earlier result still waits,
// and a stalled output holds one item in each of the two registers. Configuration is
// written through the APB-style port (registers at byte addresses 0, 4, 8, 12, 16),
// only while idle; the user is bound to this, the block itself does not enforce it.
module airbag_plausibility_crash_detector_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  apc_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output apc_pkg::out_item_t             out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [apc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [apc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [apc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready
);
  import apc_pkg::*;

  cfg_t      cfg;
  in_item_t  stage_item;
  logic      in_full;
  logic      advance;
  chk_t      chk;
  out_item_t result;

  // Move the staged item through the logic when the output register can take it.
  assign advance  = in_full && (!out_valid || out_ready);
  // Accept while the stage is empty or draining this cycle.
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // Payload register: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

  apc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apc_check u_check (
    .cfg      (cfg),
    .sample_a (stage_item.sample_a),
    .sample_b (stage_item.sample_b),
    .chk      (chk)
  );

  apc_state #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_state (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .time_stamp (stage_item.time_stamp),
    .chk        (chk),
    .cfg        (cfg),
    .result     (result)
  );

  // Output register: load a fresh result, drop valid once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(stage_item))
    else $error("staged item lost while output stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("pending result overwritten");

endmodule

// ===== hw/rtl/apc_regs.sv =====
// Configuration register file behind the APB-style port.
module apc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [apc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [apc_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [apc_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                            pready,
  output apc_pkg::cfg_t                   cfg
);
  import apc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.defect_limit      <= RST_DEFECT_LIMIT;
      cfg.clear_limit       <= RST_CLEAR_LIMIT;
      cfg.fire_limit        <= RST_FIRE_LIMIT;
      cfg.crash_level       <= RST_CRASH_LEVEL;
      cfg.tolerance_percent <= RST_TOLERANCE_PERCENT;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEFECT_LIMIT:      cfg.defect_limit      <= pwdata[THR_WIDTH-1:0];
        REG_CLEAR_LIMIT:       cfg.clear_limit       <= pwdata[THR_WIDTH-1:0];
        REG_FIRE_LIMIT:        cfg.fire_limit        <= pwdata[THR_WIDTH-1:0];
        REG_CRASH_LEVEL:       cfg.crash_level       <= signed'(pwdata[SAMPLE_WIDTH-1:0]);
        REG_TOLERANCE_PERCENT: cfg.tolerance_percent <= pwdata[TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEFECT_LIMIT:      prdata = DATA_WIDTH'(cfg.defect_limit);
      REG_CLEAR_LIMIT:       prdata = DATA_WIDTH'(cfg.clear_limit);
      REG_FIRE_LIMIT:        prdata = DATA_WIDTH'(cfg.fire_limit);
      REG_CRASH_LEVEL:       prdata = DATA_WIDTH'(unsigned'(cfg.crash_level));
      REG_TOLERANCE_PERCENT: prdata = DATA_WIDTH'(cfg.tolerance_percent);
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/apc_check.sv =====
// Exact percentage plausibility check and crash level compare of one sample pair.
module apc_check (
  input  apc_pkg::cfg_t                          cfg,
  input  logic signed [apc_pkg::SAMPLE_WIDTH-1:0] sample_a,
  input  logic signed [apc_pkg::SAMPLE_WIDTH-1:0] sample_b,
  output apc_pkg::chk_t                          chk
);
  import apc_pkg::*;

  logic signed [FACTOR_WIDTH-1:0] tol_s;
  logic signed [FACTOR_WIDTH-1:0] hi_factor;
  logic signed [FACTOR_WIDTH-1:0] lo_factor;
  logic signed [PROD_WIDTH-1:0]   lhs;
  logic signed [PROD_WIDTH-1:0]   hi_prod;
  logic signed [PROD_WIDTH-1:0]   lo_prod;

  // window factors: 100+tol is at most 227, 100-tol at least -27
  assign tol_s     = signed'({2'b00, cfg.tolerance_percent});
  assign hi_factor = PERCENT_FULL + tol_s;
  assign lo_factor = PERCENT_FULL - tol_s;

  assign lhs     = sample_a * PERCENT_FULL;
  assign hi_prod = sample_b * hi_factor;
  assign lo_prod = sample_b * lo_factor;

  assign chk.ok    = !(lhs > hi_prod) && !(lhs < lo_prod);
  assign chk.crash = (sample_a > cfg.crash_level) && (sample_b > cfg.crash_level);

endmodule

// ===== hw/rtl/apc_state.sv =====
// Detector state: last stamp, saturating counters and the sticky defect and fire flags.
module apc_state #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  logic [apc_pkg::STAMP_WIDTH-1:0]       time_stamp,
  input  apc_pkg::chk_t                         chk,
  input  apc_pkg::cfg_t                         cfg,
  output apc_pkg::out_item_t                    result
);
  import apc_pkg::*;

  localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

  logic [STAMP_WIDTH-1:0] last_time;
  logic                   plausible_flag;
  logic [COUNT_WIDTH-1:0] plausible_count;
  logic [COUNT_WIDTH-1:0] error_count;
  logic [COUNT_WIDTH-1:0] crash_count;
  logic                   defect_flag;
  logic                   fire_flag;

  logic                   plausible_flag_next;
  logic [COUNT_WIDTH-1:0] plausible_count_next;
  logic [COUNT_WIDTH-1:0] error_count_next;
  logic [COUNT_WIDTH-1:0] crash_count_next;
  logic                   defect_flag_next;
  logic                   fire_flag_next;
  logic                   fresh;
  logic [COUNT_WIDTH-1:0] pc_up;
  logic [COUNT_WIDTH-1:0] ec_up;
  logic [COUNT_WIDTH-1:0] cc_up;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  function automatic logic at_least(input logic [COUNT_WIDTH-1:0] c,
                                    input logic [THR_WIDTH-1:0] thr);
    return CMP_WIDTH'(c) >= CMP_WIDTH'(thr);
  endfunction

  assign fresh = time_stamp != last_time;
  assign pc_up = sat_inc(plausible_count);
  assign ec_up = sat_inc(error_count);
  assign cc_up = sat_inc(crash_count);

  always_comb begin
    plausible_flag_next  = plausible_flag;
    plausible_count_next = plausible_count;
    error_count_next     = error_count;
    crash_count_next     = crash_count;
    defect_flag_next     = defect_flag;
    fire_flag_next       = fire_flag;
    if (fresh) begin
      if (chk.ok) begin
        plausible_flag_next  = 1'b1;
        plausible_count_next = pc_up;
        if (at_least(pc_up, cfg.clear_limit)) begin
          error_count_next = '0;
        end
        crash_count_next = chk.crash ? cc_up : '0;
      end else begin
        plausible_flag_next  = 1'b0;
        plausible_count_next = '0;
        error_count_next     = ec_up;
      end
      // defect takes precedence; flags exclude each other
      if (!defect_flag && !fire_flag) begin
        priority if (at_least(error_count_next, cfg.defect_limit)) begin
          defect_flag_next = 1'b1;
        end else if (at_least(crash_count_next, cfg.fire_limit)) begin
          fire_flag_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time       <= '0;
      plausible_flag  <= 1'b1;
      plausible_count <= '0;
      error_count     <= '0;
      crash_count     <= '0;
      defect_flag     <= 1'b0;
      fire_flag       <= 1'b0;
    end else if (step && fresh) begin
      last_time       <= time_stamp;
      plausible_flag  <= plausible_flag_next;
      plausible_count <= plausible_count_next;
      error_count     <= error_count_next;
      crash_count     <= crash_count_next;
      defect_flag     <= defect_flag_next;
      fire_flag       <= fire_flag_next;
    end
  end

  assign result.accepted  = fresh;
  assign result.plausible = plausible_flag_next;
  assign result.defect    = defect_flag_next;
  assign result.fire      = fire_flag_next;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(defect_flag && fire_flag))
    else $error("defect and fire set together");

  a_defect_sticky: assert property (@(posedge clk) disable iff (rst)
    defect_flag |=> defect_flag)
    else $error("defect flag dropped");

  a_repeat_holds: assert property (@(posedge clk) disable iff (rst)
    step && !fresh |=> $stable(plausible_count) && $stable(error_count)
                       && $stable(crash_count) && $stable(fire_flag))
    else $error("repeated stamp changed the state");

endmodule

// ===== tb/sv/tb_airbag_plausibility_crash_detector_top.sv =====
// Self-checking testbench: random and directed sensor items against a cycle-free crash predictor.
module tb_airbag_plausibility_crash_detector_top;
  import apc_pkg::*;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
  // Margin after the last result arrives, used when settling.
  localparam int          SETTLE_CYCLES = 6;
  localparam int          LONG_HOLD     = 300;
  // Address just past the last register; writes there must be dropped.
  localparam logic [ADDR_WIDTH-1:0] SPARE_ADDR = 5'd20;

  typedef enum int {FINALE_BOTH_DUE, FINALE_FIRE, FINALE_ERRORS} finale_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  // Items waiting to be offered, and verdicts waiting for their result item.
  in_item_t  sample_q[$];
  out_item_t verdict_q[$];

  // Predictor copy of the register file and of the detector state.
  cfg_t                   det_cfg;
  logic [STAMP_WIDTH-1:0] last_stamp;
  logic                   plaus_flag;
  logic                   defect_flag;
  logic                   fire_flag;
  int unsigned            plaus_cnt;
  int unsigned            err_cnt;
  int unsigned            crash_cnt;

  logic [STAMP_WIDTH-1:0] gen_last = '0;
  logic                   in_taken = 1'b0;
  int                     tx_idle_pct = 10;
  int                     rx_idle_pct = 10;
  int                     rx_hold_left = 0;
  int                     mismatch_cnt = 0;
  int                     result_idx = 0;

  airbag_plausibility_crash_detector_top #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void detector_reset();
    det_cfg.defect_limit      = RST_DEFECT_LIMIT;
    det_cfg.clear_limit       = RST_CLEAR_LIMIT;
    det_cfg.fire_limit        = RST_FIRE_LIMIT;
    det_cfg.crash_level       = RST_CRASH_LEVEL;
    det_cfg.tolerance_percent = RST_TOLERANCE_PERCENT;
    last_stamp  = '0;
    plaus_flag  = 1'b1;
    defect_flag = 1'b0;
    fire_flag   = 1'b0;
    plaus_cnt   = 0;
    err_cnt     = 0;
    crash_cnt   = 0;
  endfunction

  // Mirror a register write; the register keeps only its own width.
  function automatic void detector_write(input logic [ADDR_WIDTH-1:0] addr,
                                         input logic [DATA_WIDTH-1:0] data);
    case (addr[4:2])
      REG_DEFECT_LIMIT:      det_cfg.defect_limit      = data[THR_WIDTH-1:0];
      REG_CLEAR_LIMIT:       det_cfg.clear_limit       = data[THR_WIDTH-1:0];
      REG_FIRE_LIMIT:        det_cfg.fire_limit        = data[THR_WIDTH-1:0];
      REG_CRASH_LEVEL:       det_cfg.crash_level       = data[SAMPLE_WIDTH-1:0];
      REG_TOLERANCE_PERCENT: det_cfg.tolerance_percent = data[TOL_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned sat_inc(input int unsigned c);
    return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
  endfunction

  // Advance the state by one item and return the result item it must produce.
  function automatic out_item_t detector_step(input in_item_t it);
    out_item_t r;
    longint    a, b, tol, lvl, lhs;
    logic      ok;
    logic      taken;
    taken = (it.time_stamp != last_stamp);
    if (taken) begin
      a   = $signed(it.sample_a);
      b   = $signed(it.sample_b);
      tol = det_cfg.tolerance_percent;
      lvl = $signed(det_cfg.crash_level);
      lhs = 100 * a;
      // Exact integer window; 100 - tol may go negative above 100 percent.
      ok  = !(lhs > (100 + tol) * b) && !(lhs < (100 - tol) * b);
      last_stamp = it.time_stamp;
      if (ok) begin
        plaus_flag = 1'b1;
        plaus_cnt  = sat_inc(plaus_cnt);
        if (plaus_cnt >= det_cfg.clear_limit) err_cnt = 0;
        if (a > lvl && b > lvl) crash_cnt = sat_inc(crash_cnt);
        else crash_cnt = 0;
      end else begin
        plaus_flag = 1'b0;
        plaus_cnt  = 0;
        err_cnt    = sat_inc(err_cnt);
      end
      // Defect takes precedence; once either flag is set both are frozen.
      if (!defect_flag && !fire_flag) begin
        if (err_cnt >= det_cfg.defect_limit) defect_flag = 1'b1;
        else if (crash_cnt >= det_cfg.fire_limit) fire_flag = 1'b1;
      end
    end
    r.accepted  = taken;
    r.plausible = plaus_flag;
    r.defect    = defect_flag;
    r.fire      = fire_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample everything at the rising edge, before the block updates
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (psel && penable && pwrite && pready) detector_write(paddr, pwdata);
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        verdict_q.push_back(detector_step(in_item));
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item pending", result_idx));
        end else begin
          want = verdict_q.pop_front();
          if (out_item.accepted !== want.accepted)
            report_mismatch($sformatf("result %0d accepted: got %b, want %b",
                                      result_idx, out_item.accepted, want.accepted));
          if (out_item.plausible !== want.plausible)
            report_mismatch($sformatf("result %0d plausible: got %b, want %b",
                                      result_idx, out_item.plausible, want.plausible));
          if (out_item.defect !== want.defect)
            report_mismatch($sformatf("result %0d defect: got %b, want %b",
                                      result_idx, out_item.defect, want.defect));
          if (out_item.fire !== want.fire)
            report_mismatch($sformatf("result %0d fire: got %b, want %b",
                                      result_idx, out_item.fire, want.fire));
        end
        result_idx++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the next item on the falling edge; hold it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_item  <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic apb_write(input logic [ADDR_WIDTH-1:0] addr,
                           input logic [DATA_WIDTH-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fill the bits above the register width with junk half the time.
  function automatic logic [DATA_WIDTH-1:0] with_junk(input logic [DATA_WIDTH-1:0] value,
                                                      input int width);
    logic [DATA_WIDTH-1:0] keep;
    keep = (32'd1 << width) - 1;
    return (value & keep) | ($urandom_range(0, 1) ? ($urandom() & ~keep) : '0);
  endfunction

  task automatic write_config(input int unsigned err_thr, input int unsigned plaus_thr,
                              input int unsigned crash_thr, input int lvl,
                              input int unsigned tol);
    apb_write({REG_DEFECT_LIMIT, 2'b00}, with_junk(err_thr, THR_WIDTH));
    apb_write({REG_CLEAR_LIMIT, 2'b00}, with_junk(plaus_thr, THR_WIDTH));
    apb_write({REG_FIRE_LIMIT, 2'b00}, with_junk(crash_thr, THR_WIDTH));
    apb_write({REG_CRASH_LEVEL, 2'b00}, with_junk(lvl, SAMPLE_WIDTH));
    apb_write({REG_TOLERANCE_PERCENT, 2'b00}, with_junk(tol, TOL_WIDTH));
  endtask

  task automatic queue_item(input logic [STAMP_WIDTH-1:0] stamp,
                            input logic signed [SAMPLE_WIDTH-1:0] a,
                            input logic signed [SAMPLE_WIDTH-1:0] b);
    in_item_t it;
    it.time_stamp = stamp;
    it.sample_a   = a;
    it.sample_b   = b;
    sample_q.push_back(it);
    gen_last = stamp;
  endtask

  task automatic queue_pair(input logic signed [SAMPLE_WIDTH-1:0] a,
                            input logic signed [SAMPLE_WIDTH-1:0] b);
    queue_item(gen_last + 1, a, b);
  endtask

  // Mostly fresh stamps; some repeats, some zeros, some anywhere in the range.
  function automatic logic [STAMP_WIDTH-1:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return gen_last;
    if (pick < 11) return '0;
    if (pick < 16) return $urandom();
    return gen_last + $urandom_range(1, 1000);
  endfunction

  // Random items shaped around the tolerance window and the crash level.
  task automatic run_phase(input int n);
    longint a, b, d, lvl;
    int     kind;
    for (int i = 0; i < n; i++) begin
      lvl  = $signed(det_cfg.crash_level);
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) b = longint'($urandom_range(0, 800)) - 400;
      else b = longint'($urandom_range(0, 65535)) - 32768;
      if (kind < 45) begin
        // just inside or just outside the window
        d = longint'($urandom_range(0, 2 * det_cfg.tolerance_percent + 4))
            - det_cfg.tolerance_percent - 2;
        a = (b * (100 + d)) / 100 + longint'($urandom_range(0, 2)) - 1;
      end else if (kind < 60) begin
        a = b;
      end else if (kind < 78) begin
        a = longint'($urandom_range(0, 65535)) - 32768;
      end else if (kind < 90) begin
        // both aimed just above the crash level and close together
        a = lvl + 1 + longint'($urandom_range(0, 50));
        b = a + longint'($urandom_range(0, 2)) - 1;
      end else begin
        case ($urandom_range(0, 5))
          0: a = -32768;
          1: a = 32767;
          2: a = 0;
          3: a = -1;
          4: a = lvl;
          default: a = lvl + 1;
        endcase
        b = ($urandom_range(0, 1)) ? a : -a;
      end
      if (a > 32767) a = 32767;
      else if (a < -32768) a = -32768;
      if (b > 32767) b = 32767;
      else if (b < -32768) b = -32768;
      queue_item(next_stamp(), a[SAMPLE_WIDTH-1:0], b[SAMPLE_WIDTH-1:0]);
    end
  endtask

  // Wait for every item to be taken and every result to arrive, then settle.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    finale_t finale;
    detector_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a zero stamp matches the cleared last stamp and is dropped.
    queue_item('0, 500, 500);
    queue_item(1, 10, 10);
    queue_item(1, -5, 7);
    drain();

    // Directed extremes with high thresholds so neither flag latches yet.
    write_config(255, 0, 255, 3, 5);
    apb_write(SPARE_ADDR, $urandom());
    queue_pair(32767, 32767);
    queue_pair(-32768, -32768);
    queue_pair(-32768, 32767);
    queue_pair(32767, -32768);
    queue_pair(0, 0);
    queue_pair(105, 100);   // upper edge of a 5 percent window
    queue_pair(106, 100);
    queue_pair(95, 100);    // lower edge
    queue_pair(94, 100);
    queue_pair(-105, -100); // negative samples swap the two bounds
    queue_pair(-95, -100);
    queue_pair(-94, -100);
    queue_pair(100, 0);
    queue_pair(0, 100);
    queue_pair(4, 4);       // just above the crash level
    queue_pair(3, 3);       // at the crash level: not a crash step
    queue_item(32'hFFFF_FFFF, 1000, 1000);
    queue_item(32'hFFFF_FFFF, 1000, -1000);
    queue_item('0, 7, 7);   // zero is a fresh stamp here
    queue_item('0, 7, 7);
    drain();

    // Zero tolerance, lowest crash level.
    write_config(255, 1, 255, -32768, 0);
    run_phase(130);
    drain();

    // Widest legal window, highest level; stall the receiver so the input backs up.
    write_config(255, 255, 255, 32767, 99);
    run_phase(60);
    @(posedge clk);
    rx_hold_left = LONG_HOLD;
    drain();

    // Tolerance beyond 100 percent, with a stretch of no idling on either side.
    write_config(255, 0, 255, 0, 127);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(150);
    drain();
    tx_idle_pct = 10;
    rx_idle_pct = 10;

    repeat (3) begin
      write_config(255, $urandom_range(0, 255), 255,
                   int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 127));
      run_phase(130);
      drain();
    end

    // Let one flag latch, then keep going to check that it sticks.
    finale = finale_t'($urandom_range(0, 2));
    case (finale)
      FINALE_BOTH_DUE: write_config(0, $urandom_range(0, 255), 0,
                                    int'($urandom_range(0, 65535)) - 32768,
                                    $urandom_range(0, 127));
      FINALE_FIRE:     write_config(255, 0, $urandom_range(1, 8), -32768, 99);
      default:         write_config($urandom_range(1, 6), 255, 255, 3, 0);
    endcase
    run_phase(90);
    drain();

    if (mismatch_cnt == 0) begin
      $display("[airbag_plausibility_crash_detector_top] OK");
    end else begin
      $display("[airbag_plausibility_crash_detector_top] ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("[airbag_plausibility_crash_detector_top] ERROR");
    $finish;
  end

endmodule
